// ===== design/tcce_pkg.sv =====
// Shared types, constants and helpers of the text console cursor engine.
package tcce_pkg;

	localparam int FONT_W   = 8;
	localparam int FONT_H   = 16;
	localparam int MAX_ROWS = 256;

	localparam int CW       = 13;
	localparam int XS_W     = 12;
	localparam int ROW_AW   = $clog2(MAX_ROWS);
	localparam int ROW_CW   = $clog2(MAX_ROWS + 1);
	localparam int TAB_W    = 4;
	localparam int TAB_MAX  = 8;
	localparam int MAX_CMDS = 64;
	localparam int CNT_W    = $clog2(MAX_CMDS + 1);
	localparam int IQ_DEPTH = 2;
	localparam int IQ_AW    = $clog2(IQ_DEPTH);
	localparam int IQ_CW    = $clog2(IQ_DEPTH + 1);
	localparam int OQ_DEPTH = 4;
	localparam int OQ_AW    = $clog2(OQ_DEPTH);
	localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

	localparam logic [7:0] CH_LAST_CTRL = 8'd31;
	localparam logic [7:0] CH_DEL       = 8'd127;
	localparam logic [7:0] CH_SPACE     = 8'd32;
	localparam logic [7:0] CH_BS        = 8'd8;
	localparam logic [7:0] CH_TAB       = 8'd9;
	localparam logic [7:0] CH_LF        = 8'd10;
	localparam logic [7:0] CH_FF        = 8'd12;
	localparam logic [7:0] CH_CR        = 8'd13;

	localparam logic [1:0] CFG_SCREEN_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_SCREEN_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_TAB_WIDTH     = 2'd2;

	localparam logic [CW-1:0]    SW_RESET = 13'd1024;
	localparam logic [CW-1:0]    SH_RESET = 13'd768;
	localparam logic [TAB_W-1:0] TW_RESET = 4'd4;

	localparam logic [31:0] BAR_COLOR = 32'hFFFF_FFFF;

	typedef enum logic [2:0] {
		OP_NOP, OP_PRINT, OP_BS, OP_TAB, OP_LF, OP_FF, OP_CR
	} op_t;

	typedef enum logic [2:0] {
		CMD_SPAN   = 3'd0,
		CMD_GLYPH  = 3'd1,
		CMD_BAR    = 3'd2,
		CMD_SCROLL = 3'd3,
		CMD_CLEAR  = 3'd4
	} cmd_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_P0, ST_P1, ST_P3, ST_P4, ST_P5, ST_P6, ST_P7, ST_P8,
		ST_S0, ST_SRD, ST_SWR, ST_S1,
		ST_B0, ST_E0, ST_E1, ST_E2, ST_BL0, ST_BL1, ST_BL2,
		ST_T0, ST_TEND, ST_L0, ST_L1, ST_F0, ST_F1, ST_C0, ST_FIN
	} st_t;

	typedef struct packed {
		op_t         op;
		logic [7:0]  ch;
		logic [31:0] fg;
		logic [31:0] bg;
		logic        mark;
	} item_t;

	typedef struct packed {
		cmd_t            cmd;
		logic [XS_W-1:0] x_start;
		logic [CW-1:0]   x_end;
		logic [XS_W-1:0] y_top;
		logic [7:0]      glyph;
		logic [31:0]     fore;
		logic [31:0]     back;
		logic            last;
	} out_t;

	typedef struct packed {
		logic [CW-1:0]    sw;
		logic [CW-1:0]    sh;
		logic [TAB_W-1:0] tw;
	} cfg_t;

	function automatic out_t mk_cmd(cmd_t c, logic [CW-1:0] xs, logic [CW-1:0] xe,
			logic [CW-1:0] y, logic [7:0] g, logic [31:0] f, logic [31:0] b);
		out_t o;
		o.cmd     = c;
		o.x_start = xs[XS_W-1:0];
		o.x_end   = xe;
		o.y_top   = y[XS_W-1:0];
		o.glyph   = g;
		o.fore    = f;
		o.back    = b;
		o.last    = 1'b0;
		return o;
	endfunction

	function automatic logic [CW-1:0] row_of(logic [CW-1:0] y);
		return CW'(y / FONT_H);
	endfunction

endpackage

// ===== design/text_console_cursor_engine_top.sv =====
// Text console cursor engine: character queue, cursor sequencer, command queue.
// Each character runs through the sequencer states of its kind, after a scroll where one comes
// first; a tab runs up to 8 printables, and a scroll also shifts each text row held in the
// row end table up by one.
// Throughput: one character at a time, one sequencer step a cycle while the command queue is not full.
// Reset: cursor, printed cursor, queues and row table valid bits clear at once.
module text_console_cursor_engine_top import tcce_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [7:0]       char_code,
	input  logic [31:0]      fg_color,
	input  logic [31:0]      bg_color,
	input  logic             mark_printed,
	output logic             empty,
	input  logic             pop,
	output logic [2:0]       cmd,
	output logic [XS_W-1:0]  x_start,
	output logic [CW-1:0]    x_end,
	output logic [XS_W-1:0]  y_top,
	output logic [7:0]       glyph,
	output logic [31:0]      fore,
	output logic [31:0]      back,
	output logic             last,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [CW-1:0]    cfg_data
);

	cfg_t  cfg_q;
	logic  iq_valid, iq_pop, oq_full, oq_push;
	item_t iq_head;
	out_t  oq_data, oq_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sw <= SW_RESET;
			cfg_q.sh <= SH_RESET;
			cfg_q.tw <= TW_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SCREEN_WIDTH:  cfg_q.sw <= cfg_data;
				CFG_SCREEN_HEIGHT: cfg_q.sh <= cfg_data;
				CFG_TAB_WIDTH:     cfg_q.tw <= cfg_data[TAB_W-1:0];
				default: ;
			endcase
		end
	end

	tcce_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.char_code    (char_code),
		.fg_color     (fg_color),
		.bg_color     (bg_color),
		.mark_printed (mark_printed),
		.pop          (iq_pop),
		.valid        (iq_valid),
		.head         (iq_head)
	);

	tcce_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.iq_valid (iq_valid),
		.iq_head  (iq_head),
		.iq_pop   (iq_pop),
		.oq_full  (oq_full),
		.oq_push  (oq_push),
		.oq_data  (oq_data)
	);

	tcce_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (oq_push),
		.data   (oq_data),
		.full   (oq_full),
		.pop    (pop),
		.empty  (empty),
		.head   (oq_head)
	);

	assign cmd     = oq_head.cmd;
	assign x_start = oq_head.x_start;
	assign x_end   = oq_head.x_end;
	assign y_top   = oq_head.y_top;
	assign glyph   = oq_head.glyph;
	assign fore    = oq_head.fore;
	assign back    = oq_head.back;
	assign last    = oq_head.last;

endmodule

// ===== design/tcce_front.sv =====
// Front end: accepts characters, decodes them and queues them for the sequencer.
module tcce_front import tcce_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  char_code,
	input  logic [31:0] fg_color,
	input  logic [31:0] bg_color,
	input  logic        mark_printed,
	input  logic        pop,
	output logic        valid,
	output item_t       head
);

	item_t             iq_q [IQ_DEPTH];
	logic [IQ_AW-1:0]  wr_ptr_q;
	logic [IQ_AW-1:0]  rd_ptr_q;
	logic [IQ_CW-1:0]  cnt_q;
	logic              do_push;
	logic              do_pop;
	item_t             dec;

	function automatic op_t classify(logic [7:0] c);
		op_t op;
		op = OP_NOP;
		if (c > CH_LAST_CTRL && c < CH_DEL)
			op = OP_PRINT;
		else if (c == CH_BS)
			op = OP_BS;
		else if (c == CH_TAB)
			op = OP_TAB;
		else if (c == CH_LF)
			op = OP_LF;
		else if (c == CH_FF)
			op = OP_FF;
		else if (c == CH_CR)
			op = OP_CR;
		return op;
	endfunction

	assign full    = (cnt_q == IQ_CW'(IQ_DEPTH));
	assign valid   = (cnt_q != '0);
	assign head    = iq_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_comb begin
		dec.op   = classify(char_code);
		dec.ch   = char_code;
		dec.fg   = fg_color;
		dec.bg   = bg_color;
		dec.mark = mark_printed;
	end

	always_ff @(posedge clk) begin
		if (do_push)
			iq_q[wr_ptr_q] <= dec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + IQ_AW'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + IQ_AW'(1);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + IQ_CW'(1);
			else if (!do_push && do_pop)
				cnt_q <= cnt_q - IQ_CW'(1);
		end
	end

endmodule

// ===== design/tcce_back.sv =====
// Back end: cursor sequencer, row end table and command emission.
module tcce_back import tcce_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  iq_valid,
	input  item_t iq_head,
	output logic  iq_pop,
	input  logic  oq_full,
	output logic  oq_push,
	output out_t  oq_data
);

	st_t st_q, st_n;

	logic [CW-1:0]     cx_q, cy_q, px_q, py_q, tmpx_q, tmpy_q;
	logic [7:0]        pchar_q;
	logic [31:0]       fg_q, bg_q;
	logic              mark_q, is_tab_q, ret_p4_q, prow_ok_q;
	logic [TAB_W-1:0]  tcnt_q;
	logic [ROW_AW-1:0] idx_q;
	logic [CNT_W-1:0]  cnt_q;
	out_t              pend_q;
	logic              pend_v_q;

	logic [CW-1:0]     row_mem [MAX_ROWS];
	logic [MAX_ROWS-1:0] row_vld_q;
	logic [CW-1:0]     rd_q;
	logic              rd_vld_q;

	logic              step, emit_v, fin, cur_set, wr_en, rd_en, cnt_ok;
	out_t              emit_w;
	logic [CW-1:0]     cur_x_n, cur_y_n, wr_row, wr_val;
	logic [ROW_AW-1:0] rd_addr, wr_addr;

	// derived values
	logic [CW-1:0]     q_rows, m_rows, scr_y, row_c, prow, pyn, nx, rd_val;
	logic [TAB_W-1:0]  t_eff, tab_cnt;
	logic [CW:0]       tsum, tmag;
	logic              span_now;

	assign step    = !oq_full;
	assign cnt_ok  = (cnt_q < CNT_W'(MAX_CMDS));
	assign wr_addr = wr_row[ROW_AW-1:0];

	always_comb begin
		q_rows   = CW'(cfg.sh / FONT_H);
		m_rows   = (q_rows < CW'(MAX_ROWS)) ? q_rows : CW'(MAX_ROWS);
		scr_y    = (q_rows != '0) ? CW'((q_rows - CW'(1)) * FONT_H) : '0;
		row_c    = row_of(cy_q);
		prow     = (row_c != '0) ? row_c - CW'(1) : '0;
		pyn      = (cy_q >= CW'(FONT_H)) ? cy_q - CW'(FONT_H) : '0;
		nx       = (cx_q >= CW'(FONT_W)) ? cx_q - CW'(FONT_W) : '0;
		rd_val   = rd_vld_q ? rd_q : '0;
		span_now = ({1'b0, cx_q} + (CW+1)'(FONT_W)) >= {1'b0, cfg.sw};
		t_eff    = (cfg.tw > TAB_W'(TAB_MAX)) ? TAB_W'(TAB_MAX) : cfg.tw;
		tsum     = {1'b0, cx_q} + (CW+1)'(t_eff * FONT_W);
		tmag     = tsum - {1'b0, cfg.sw};
		// past the edge the count shrinks by whole cells, truncated
		if (tsum > {1'b0, cfg.sw}) begin
			if ((tmag / FONT_W) < (CW+1)'(t_eff))
				tab_cnt = t_eff - TAB_W'(tmag / FONT_W);
			else
				tab_cnt = '0;
		end else begin
			tab_cnt = t_eff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			st_q <= ST_IDLE;
		else if (step)
			st_q <= st_n;
	end

	always_comb begin
		st_n    = st_q;
		emit_v  = 1'b0;
		emit_w  = mk_cmd(CMD_SPAN, cx_q, cfg.sw, cy_q, 8'd0, 32'd0, bg_q);
		wr_en   = 1'b0;
		wr_row  = row_c;
		wr_val  = cx_q;
		rd_en   = 1'b0;
		rd_addr = prow[ROW_AW-1:0];
		cur_set = 1'b0;
		cur_x_n = cx_q;
		cur_y_n = cy_q;
		iq_pop  = 1'b0;
		fin     = 1'b0;
		unique case (st_q)
			ST_IDLE: begin
				if (iq_valid) begin
					iq_pop = step;
					unique case (iq_head.op)
						OP_PRINT: st_n = ST_P0;
						OP_BS:    st_n = ST_B0;
						OP_TAB:   st_n = ST_T0;
						OP_LF:    st_n = ST_L0;
						OP_FF:    st_n = ST_F0;
						OP_CR:    st_n = ST_C0;
						default:  st_n = ST_FIN;
					endcase
				end
			end
			ST_P0: begin
				if (span_now) begin
					emit_v = 1'b1;
					st_n   = ST_P1;
				end else begin
					st_n = ST_P3;
				end
			end
			ST_P1: begin
				cur_set = 1'b1;
				cur_x_n = '0;
				cur_y_n = cy_q + CW'(FONT_H);
				wr_en   = 1'b1;
				wr_row  = row_of(cur_y_n);
				wr_val  = '0;
				st_n    = ST_P3;
			end
			ST_P3: begin
				if (({1'b0, cy_q} + (CW+1)'(FONT_H)) > {1'b0, cfg.sh})
					st_n = ST_S0;
				else
					st_n = ST_P4;
			end
			ST_P4: begin
				emit_v = 1'b1;
				emit_w = mk_cmd(CMD_GLYPH, cx_q, '0, cy_q, pchar_q, fg_q, bg_q);
				st_n   = ST_P5;
			end
			ST_P5: begin
				cur_set = 1'b1;
				cur_x_n = cx_q + CW'(FONT_W);
				st_n    = ST_P6;
			end
			ST_P6: begin
				if (span_now) begin
					emit_v = 1'b1;
					st_n   = ST_P7;
				end else begin
					st_n = ST_P8;
				end
			end
			ST_P7: begin
				cur_set = 1'b1;
				cur_x_n = '0;
				cur_y_n = cy_q + CW'(FONT_H);
				st_n    = ST_P8;
			end
			ST_P8: begin
				wr_en = 1'b1;
				if (!is_tab_q)
					st_n = ST_FIN;
				else if (tcnt_q > TAB_W'(1))
					st_n = ST_P0;
				else
					st_n = ST_TEND;
			end
			ST_S0: begin
				emit_v = 1'b1;
				emit_w = mk_cmd(CMD_SCROLL, '0, '0, '0, 8'd0, 32'd0, 32'd0);
				st_n   = (m_rows >= CW'(2)) ? ST_SRD : ST_S1;
			end
			ST_SRD: begin
				rd_en   = 1'b1;
				rd_addr = idx_q + ROW_AW'(1);
				st_n    = ST_SWR;
			end
			ST_SWR: begin
				wr_en  = 1'b1;
				wr_row = CW'(idx_q);
				wr_val = rd_val;
				st_n   = ((CW'(idx_q) + CW'(2)) < m_rows) ? ST_SRD : ST_S1;
			end
			ST_S1: begin
				cur_set = 1'b1;
				cur_x_n = '0;
				cur_y_n = scr_y;
				wr_en   = 1'b1;
				wr_row  = row_of(scr_y);
				wr_val  = '0;
				st_n    = ret_p4_q ? ST_P4 : ST_FIN;
			end
			ST_B0: begin
				if (py_q == cy_q)
					st_n = (cx_q > px_q) ? ST_E0 : ST_FIN;
				else if (py_q < cy_q)
					st_n = (cx_q != '0) ? ST_E0 : ST_BL0;
				else
					st_n = ST_FIN;
			end
			ST_E0: begin
				emit_v = 1'b1;
				emit_w = mk_cmd(CMD_GLYPH, cx_q, '0, cy_q, CH_SPACE, fg_q, bg_q);
				st_n   = ST_E1;
			end
			ST_E1: begin
				emit_v = 1'b1;
				emit_w = mk_cmd(CMD_GLYPH, tmpx_q, '0, cy_q, CH_SPACE, fg_q, bg_q);
				st_n   = ST_E2;
			end
			ST_E2: begin
				cur_set = 1'b1;
				cur_x_n = tmpx_q;
				wr_en   = 1'b1;
				wr_val  = tmpx_q;
				st_n    = ST_FIN;
			end
			ST_BL0: begin
				rd_en  = 1'b1;
				emit_v = 1'b1;
				emit_w = mk_cmd(CMD_GLYPH, cx_q, '0, cy_q, CH_SPACE, fg_q, bg_q);
				st_n   = ST_BL1;
			end
			ST_BL1: begin
				emit_v = 1'b1;
				emit_w = mk_cmd(CMD_GLYPH, prow_ok_q ? rd_val : '0, '0, tmpy_q,
					CH_SPACE, fg_q, bg_q);
				st_n   = ST_BL2;
			end
			ST_BL2: begin
				cur_set = 1'b1;
				cur_x_n = tmpx_q;
				cur_y_n = tmpy_q;
				st_n    = ST_FIN;
			end
			ST_T0: begin
				st_n = (tab_cnt == '0) ? ST_TEND : ST_P0;
			end
			ST_TEND: begin
				wr_en = 1'b1;
				st_n  = ST_FIN;
			end
			ST_L0: begin
				emit_v = 1'b1;
				wr_en  = 1'b1;
				st_n   = ST_L1;
			end
			ST_L1: begin
				if (({1'b0, cy_q} + (CW+1)'(2 * FONT_H)) <= {1'b0, cfg.sh}) begin
					cur_set = 1'b1;
					cur_x_n = '0;
					cur_y_n = cy_q + CW'(FONT_H);
					wr_en   = 1'b1;
					wr_row  = row_of(cur_y_n);
					wr_val  = '0;
					st_n    = ST_FIN;
				end else begin
					st_n = ST_S0;
				end
			end
			ST_F0: begin
				emit_v = 1'b1;
				emit_w = mk_cmd(CMD_CLEAR, '0, '0, '0, 8'd0, 32'd0, 32'd0);
				st_n   = ST_F1;
			end
			ST_F1: begin
				cur_set = 1'b1;
				cur_x_n = '0;
				cur_y_n = '0;
				st_n    = ST_FIN;
			end
			ST_C0: begin
				cur_set = 1'b1;
				cur_x_n = '0;
				wr_en   = 1'b1;
				wr_val  = '0;
				st_n    = ST_FIN;
			end
			ST_FIN: begin
				fin  = 1'b1;
				st_n = ST_IDLE;
			end
			default: st_n = ST_IDLE;
		endcase
		// every cursor move draws the bar when it fits
		if (cur_set && (({1'b0, cur_x_n} + (CW+1)'(2)) < {1'b0, cfg.sw})) begin
			emit_v = 1'b1;
			emit_w = mk_cmd(CMD_BAR, cur_x_n, '0, cur_y_n, 8'd0, BAR_COLOR, 32'd0);
		end
	end

	// one word held back so the final one can carry last
	always_comb begin
		oq_push      = step && pend_v_q && ((emit_v && cnt_ok) || fin);
		oq_data      = pend_q;
		oq_data.last = fin;
	end

	always_ff @(posedge clk) begin
		if (step && wr_en && (wr_row < CW'(MAX_ROWS)))
			row_mem[wr_addr] <= wr_val;
		if (step && rd_en)
			rd_q <= row_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rd_vld_q  <= 1'b0;
		end else if (step) begin
			if (wr_en && (wr_row < CW'(MAX_ROWS)))
				row_vld_q[wr_addr] <= 1'b1;
			if (rd_en)
				rd_vld_q <= row_vld_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q     <= '0;
			cy_q     <= '0;
			px_q     <= '0;
			py_q     <= '0;
			cnt_q    <= '0;
			pend_v_q <= 1'b0;
			is_tab_q <= 1'b0;
			ret_p4_q <= 1'b0;
			tcnt_q   <= '0;
			idx_q    <= '0;
		end else if (step) begin
			if (cur_set) begin
				cx_q <= cur_x_n;
				cy_q <= cur_y_n;
			end
			if (iq_pop) begin
				cnt_q    <= '0;
				is_tab_q <= 1'b0;
			end
			if (emit_v && cnt_ok) begin
				pend_v_q <= 1'b1;
				cnt_q    <= cnt_q + CNT_W'(1);
			end
			if (fin) begin
				pend_v_q <= 1'b0;
				if (mark_q) begin
					px_q <= cx_q;
					py_q <= cy_q;
				end
			end
			unique case (st_q)
				ST_P3:   ret_p4_q <= 1'b1;
				ST_L1:   ret_p4_q <= 1'b0;
				ST_S0:   idx_q <= '0;
				ST_SWR:  idx_q <= idx_q + ROW_AW'(1);
				ST_P8:   tcnt_q <= tcnt_q - TAB_W'(1);
				ST_T0: begin
					tcnt_q   <= tab_cnt;
					is_tab_q <= 1'b1;
				end
				ST_S1: begin
					if (py_q >= CW'(FONT_H)) begin
						py_q <= py_q - CW'(FONT_H);
					end else begin
						px_q <= '0;
						py_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			if (emit_v && cnt_ok)
				pend_q <= emit_w;
			if (iq_pop) begin
				pchar_q <= iq_head.ch;
				fg_q    <= iq_head.fg;
				bg_q    <= iq_head.bg;
				mark_q  <= iq_head.mark;
			end
			unique case (st_q)
				ST_T0:  pchar_q <= CH_SPACE;
				ST_E0:  tmpx_q <= nx;
				ST_BL0: begin
					tmpy_q    <= pyn;
					prow_ok_q <= (prow < CW'(MAX_ROWS));
				end
				ST_BL1: tmpx_q <= prow_ok_q ? rd_val : '0;
				default: ;
			endcase
		end
	end

endmodule

// ===== design/tcce_outq.sv =====
// Result queue between the sequencer and the output ports.
module tcce_outq import tcce_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  out_t data,
	output logic full,
	input  logic pop,
	output logic empty,
	output out_t head
);

	out_t             oq_q [OQ_DEPTH];
	logic [OQ_AW-1:0] wr_ptr_q;
	logic [OQ_AW-1:0] rd_ptr_q;
	logic [OQ_CW-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == OQ_CW'(OQ_DEPTH));
	assign empty   = (cnt_q == '0);
	assign head    = oq_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push)
			oq_q[wr_ptr_q] <= data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + OQ_AW'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + OQ_AW'(1);
			if (do_push && !do_pop)
				cnt_q <= cnt_q + OQ_CW'(1);
			else if (!do_push && do_pop)
				cnt_q <= cnt_q - OQ_CW'(1);
		end
	end

endmodule

// ===== tb/sv/tcce_checker.sv =====
// Checker for the text console cursor engine: command predictor and word compare.
`timescale 1ns / 100ps
module tcce_checker import tcce_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic             full,
	input  logic [7:0]       char_code,
	input  logic [31:0]      fg_color,
	input  logic [31:0]      bg_color,
	input  logic             mark_printed,
	input  logic             empty,
	input  logic             pop,
	input  logic [2:0]       cmd,
	input  logic [XS_W-1:0]  x_start,
	input  logic [CW-1:0]    x_end,
	input  logic [XS_W-1:0]  y_top,
	input  logic [7:0]       glyph,
	input  logic [31:0]      fore,
	input  logic [31:0]      back,
	input  logic             last,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [CW-1:0]    cfg_data,
	output int               errors,
	output int               pending
);

	localparam int unsigned M13 = 32'h1FFF;

	int unsigned scr_w, scr_h, tab_cells;
	int unsigned cur_x, cur_y, prn_x, prn_y;
	int unsigned row_end[MAX_ROWS];
	logic [31:0] ink, paper;
	out_t        char_cmds[$];
	out_t        cmd_q[$];

	task automatic report(string what, longint unsigned got, longint unsigned want);
		errors++;
		$display("[%0t] mismatch %s: got %0h expected %0h", $realtime, what, got, want);
	endtask

	task automatic add_cmd(cmd_t c, int unsigned xs, int unsigned xe, int unsigned y,
			logic [7:0] g, logic [31:0] f, logic [31:0] b);
		out_t o;
		if (char_cmds.size() >= MAX_CMDS)
			return;
		o.cmd     = c;
		o.x_start = xs[XS_W-1:0];
		o.x_end   = xe[CW-1:0];
		o.y_top   = y[XS_W-1:0];
		o.glyph   = g;
		o.fore    = f;
		o.back    = b;
		o.last    = 1'b0;
		char_cmds.push_back(o);
	endtask

	task automatic set_row_end(int unsigned y, int unsigned v);
		int unsigned r;
		r = y / FONT_H;
		if (r < MAX_ROWS)
			row_end[r] = v & M13;
	endtask

	task automatic move_to(int unsigned y, int unsigned x);
		cur_x = x & M13;
		cur_y = y & M13;
		if (cur_x + 2 < scr_w)
			add_cmd(CMD_BAR, cur_x, 0, cur_y, 8'h00, BAR_COLOR, 32'h0);
	endtask

	task automatic fill_to_edge();
		add_cmd(CMD_SPAN, cur_x, scr_w, cur_y, 8'h00, 32'h0, paper);
	endtask

	task automatic scroll_up();
		int unsigned rows, y;
		rows = scr_h / FONT_H;
		y = 0;
		if (rows >= 1) begin
			y = (rows - 1) * FONT_H;
			for (int unsigned i = 0; i + 1 < rows && i + 1 < MAX_ROWS; i++)
				row_end[i] = row_end[i + 1];
		end
		add_cmd(CMD_SCROLL, 0, 0, 0, 8'h00, 32'h0, 32'h0);
		move_to(y, 0);
		set_row_end(cur_y, 0);
		if (prn_y >= FONT_H) begin
			prn_y -= FONT_H;
		end else begin
			prn_x = 0;
			prn_y = 0;
		end
	endtask

	task automatic put_glyph(logic [7:0] c);
		if (cur_x + FONT_W >= scr_w) begin
			fill_to_edge();
			move_to(cur_y + FONT_H, 0);
			set_row_end(cur_y, cur_x);
		end
		if (cur_y + FONT_H > scr_h)
			scroll_up();
		add_cmd(CMD_GLYPH, cur_x, 0, cur_y, c, ink, paper);
		move_to(cur_y, cur_x + FONT_W);
		if (cur_x + FONT_W >= scr_w) begin
			fill_to_edge();
			move_to(cur_y + FONT_H, 0);
		end
		set_row_end(cur_y, cur_x);
	endtask

	task automatic erase_cell();
		int unsigned nx;
		nx = (cur_x >= FONT_W) ? cur_x - FONT_W : 0;
		add_cmd(CMD_GLYPH, cur_x, 0, cur_y, CH_SPACE, ink, paper);
		add_cmd(CMD_GLYPH, nx, 0, cur_y, CH_SPACE, ink, paper);
		move_to(cur_y, nx);
		set_row_end(cur_y, cur_x);
	endtask

	task automatic do_backspace();
		int unsigned r, pr, ny, nx;
		if (prn_y == cur_y) begin
			if (cur_x > prn_x)
				erase_cell();
		end else if (prn_y < cur_y) begin
			if (cur_x > 0) begin
				erase_cell();
			end else begin
				// back up to the end of the previous text row
				r  = cur_y / FONT_H;
				pr = (r >= 1) ? r - 1 : 0;
				ny = (cur_y >= FONT_H) ? cur_y - FONT_H : 0;
				nx = (pr < MAX_ROWS) ? row_end[pr] : 0;
				add_cmd(CMD_GLYPH, cur_x, 0, cur_y, CH_SPACE, ink, paper);
				add_cmd(CMD_GLYPH, nx, 0, ny, CH_SPACE, ink, paper);
				move_to(ny, nx);
			end
		end
	endtask

	task automatic do_tab();
		int t, room;
		t = (tab_cells > TAB_MAX) ? TAB_MAX : int'(tab_cells);
		room = int'(scr_w) - (int'(cur_x) + t * FONT_W);
		if (room < 0)
			room = t + room / FONT_W;
		else
			room = t;
		while (room > 0) begin
			put_glyph(CH_SPACE);
			room--;
		end
		set_row_end(cur_y, cur_x);
	endtask

	task automatic do_line_feed();
		fill_to_edge();
		set_row_end(cur_y, cur_x);
		if (int'(cur_y) + FONT_H <= int'(scr_h) - FONT_H) begin
			move_to(cur_y + FONT_H, 0);
			set_row_end(cur_y, 0);
		end else begin
			scroll_up();
		end
	endtask

	task automatic predict_char(logic [7:0] c, logic [31:0] f, logic [31:0] b, logic m);
		char_cmds.delete();
		ink   = f;
		paper = b;
		if (c > CH_LAST_CTRL && c < CH_DEL) begin
			put_glyph(c);
		end else if (c == CH_BS) begin
			do_backspace();
		end else if (c == CH_TAB) begin
			do_tab();
		end else if (c == CH_LF) begin
			do_line_feed();
		end else if (c == CH_FF) begin
			add_cmd(CMD_CLEAR, 0, 0, 0, 8'h00, 32'h0, 32'h0);
			move_to(0, 0);
		end else if (c == CH_CR) begin
			move_to(cur_y, 0);
			set_row_end(cur_y, cur_x);
		end
		if (m) begin
			prn_x = cur_x;
			prn_y = cur_y;
		end
		if (char_cmds.size() > 0)
			char_cmds[char_cmds.size() - 1].last = 1'b1;
		foreach (char_cmds[i])
			cmd_q.push_back(char_cmds[i]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_t want;
		if (!arst_n) begin
			scr_w     = SW_RESET;
			scr_h     = SH_RESET;
			tab_cells = TW_RESET;
			cur_x     = 0;
			cur_y     = 0;
			prn_x     = 0;
			prn_y     = 0;
			foreach (row_end[i])
				row_end[i] = 0;
			cmd_q.delete();
			errors  = 0;
			pending = 0;
		end else begin
			if (pop && !empty) begin
				if (cmd_q.size() == 0) begin
					report("unexpected word cmd", cmd, 0);
				end else begin
					want = cmd_q.pop_front();
					if (cmd !== want.cmd)         report("cmd", cmd, want.cmd);
					if (x_start !== want.x_start) report("x_start", x_start, want.x_start);
					if (x_end !== want.x_end)     report("x_end", x_end, want.x_end);
					if (y_top !== want.y_top)     report("y_top", y_top, want.y_top);
					if (glyph !== want.glyph)     report("glyph", glyph, want.glyph);
					if (fore !== want.fore)       report("fore", fore, want.fore);
					if (back !== want.back)       report("back", back, want.back);
					if (last !== want.last)       report("last", last, want.last);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_SCREEN_WIDTH:  scr_w = cfg_data;
					CFG_SCREEN_HEIGHT: scr_h = cfg_data;
					CFG_TAB_WIDTH:     tab_cells = cfg_data[TAB_W-1:0];
					default: ;
				endcase
			end
			if (push && !full)
				predict_char(char_code, fg_color, bg_color, mark_printed);
			pending = cmd_q.size();
		end
	end

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench top for the text console cursor engine: stimulus and verdict.
`timescale 1ns / 100ps
module tb_top;
	import tcce_pkg::*;

	localparam int STALL_LIMIT = 30000;
	localparam int DRAIN       = 700;

	logic            clk = 1'b0;
	logic            arst_n = 1'b0;
	logic            push = 1'b0;
	logic            full;
	logic [7:0]      char_code = '0;
	logic [31:0]     fg_color = '0;
	logic [31:0]     bg_color = '0;
	logic            mark_printed = 1'b0;
	logic            empty;
	logic            pop = 1'b0;
	logic [2:0]      cmd;
	logic [XS_W-1:0] x_start;
	logic [CW-1:0]   x_end;
	logic [XS_W-1:0] y_top;
	logic [7:0]      glyph;
	logic [31:0]     fore;
	logic [31:0]     back;
	logic            last;
	logic            cfg_we = 1'b0;
	logic [1:0]      cfg_index = CFG_SCREEN_WIDTH;
	logic [CW-1:0]   cfg_data = '0;
	int              errors;
	int              pending;
	int              send_idle_pct = 0;
	int              pop_stall_pct = 0;
	int              quiet_cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	text_console_cursor_engine_top DUT (.*);

	tcce_checker u_chk (.*);

	always @(posedge clk)
		pop <= ($urandom_range(99) >= pop_stall_pct);

	// stall watchdog: no word moved on any port
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic send_char(logic [7:0] c, logic [31:0] f, logic [31:0] b, logic m);
		logic was_full;
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push         <= 1'b1;
		char_code    <= c;
		fg_color     <= f;
		bg_color     <= b;
		mark_printed <= m;
		do begin
			@(negedge clk);
			was_full = full;
			@(posedge clk);
		end while (was_full);
	endtask

	function automatic logic [7:0] pick_char();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 52) return 8'($urandom_range(32, 126));
		if (r < 64) return CH_BS;
		if (r < 71) return CH_TAB;
		if (r < 81) return CH_LF;
		if (r < 86) return CH_CR;
		if (r < 89) return CH_FF;
		if (r < 94) return 8'($urandom_range(0, 31));
		return 8'($urandom_range(127, 255));
	endfunction

	task automatic wait_idle();
		push <= 1'b0;
		do @(negedge clk); while (pending != 0);
		// a char with no output may still be in flight
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic program_regs(int unsigned w, int unsigned h, int unsigned t);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_SCREEN_WIDTH;
		cfg_data  <= CW'(w);
		@(posedge clk);
		cfg_index <= CFG_SCREEN_HEIGHT;
		cfg_data  <= CW'(h);
		@(posedge clk);
		cfg_index <= CFG_TAB_WIDTH;
		cfg_data  <= CW'(t);
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic random_burst(int n);
		int mix [4][2] = '{'{0, 0}, '{58, 0}, '{0, 58}, '{35, 35}};
		for (int k = 0; k < 4; k++) begin
			send_idle_pct = mix[k][0];
			pop_stall_pct = mix[k][1];
			repeat (n) send_char(pick_char(), $urandom, $urandom, 1'($urandom));
		end
		send_idle_pct = 0;
		pop_stall_pct = 0;
	endtask

	initial begin
		int unsigned widths  [7] = '{16, 4096, 40, 24, 64, 4096, 1024};
		int unsigned heights [7] = '{16, 4096, 48, 8, 40, 16, 768};
		int unsigned tabs    [7] = '{1, 8, 15, 0, 3, 2, 4};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes and each control code at reset settings
		send_char(CH_BS, 32'h0, 32'h0, 1'b0);
		send_char(CH_SPACE, 32'h0, 32'hFFFF_FFFF, 1'b0);
		send_char(8'd126, 32'hFFFF_FFFF, 32'h0, 1'b1);
		send_char(CH_BS, 32'hA5A5_5A5A, 32'h5A5A_A5A5, 1'b0);
		send_char(8'd65, 32'h1234_5678, 32'h8765_4321, 1'b0);
		send_char(CH_BS, 32'h0, 32'h0, 1'b0);
		send_char(CH_TAB, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		send_char(CH_CR, 32'h0, 32'h0, 1'b0);
		send_char(CH_LF, 32'h0, 32'hFFFF_FFFF, 1'b0);
		send_char(CH_BS, 32'h0, 32'h0, 1'b0);
		send_char(8'd0, 32'h0, 32'h0, 1'b1);
		send_char(CH_LAST_CTRL, 32'h0, 32'h0, 1'b0);
		send_char(CH_DEL, 32'h0, 32'h0, 1'b0);
		send_char(8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		send_char(CH_FF, 32'h0, 32'h0, 1'b0);
		send_char(CH_BS, 32'h0, 32'h0, 1'b0);
		random_burst(4);
		wait_idle();

		foreach (widths[p]) begin
			program_regs(widths[p], heights[p], tabs[p]);
			// a short line of text first so wraps and backspaces have history
			repeat (6) send_char(8'($urandom_range(32, 126)), $urandom, $urandom, 1'b0);
			send_char(CH_LF, $urandom, $urandom, 1'($urandom));
			random_burst(12);
			wait_idle();
		end

		if (errors == 0 && pending == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
